@@ rtl/core/piq_pkg.sv @@
// ----------------------------------------------------------------------------
// piq_pkg
// Shared constants, codes and control types for the positional insert queue.
// ----------------------------------------------------------------------------
`default_nettype none

package piq_pkg;

   // Queue geometry and field widths.
   localparam int DEPTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = 6;
   localparam int VAL_W = 32;
   localparam int POS_W = 8;
   localparam int OP_W  = 2;
   localparam int ST_W  = 2;

   // Reset value of the max_position register.
   localparam logic [CNT_W-1:0] MAXPOS_RESET = CNT_W'(16);

   // Operation codes; the fourth code is a no-op.
   typedef enum logic [OP_W-1:0] {
      OP_ENQ = 2'd0,
      OP_DEQ = 2'd1,
      OP_CLR = 2'd2,
      OP_NOP = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic execute;
   } piq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy;
   } piq_stat_type;

endpackage

`default_nettype wire

@@ rtl/core/piq_req_if.sv @@
// ----------------------------------------------------------------------------
// piq_req_if
// Request channel: operation, value and insertion position.
// ----------------------------------------------------------------------------
`default_nettype none

interface piq_req_if
   import piq_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [VAL_W-1:0]   value;
   logic [POS_W-1:0]   position;

   modport source (output valid, output op, output value, output position, input ready);
   modport sink   (input valid, input op, input value, input position, output ready);
endinterface

`default_nettype wire

@@ rtl/core/piq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// piq_rsp_if
// Response channel: status, dequeued value and new entry count.
// ----------------------------------------------------------------------------
`default_nettype none

interface piq_rsp_if
   import piq_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [ST_W-1:0]         status;
   logic signed [VAL_W-1:0] head_value;
   logic [CNT_W-1:0]        count;

   modport source (output valid, output status, output head_value, output count,
                   input ready);
   modport sink   (input valid, input status, input head_value, input count,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/core/piq_csr_if.sv @@
// ----------------------------------------------------------------------------
// piq_csr_if
// Configuration write channel carrying the max_position register value.
// ----------------------------------------------------------------------------
`default_nettype none

interface piq_csr_if
   import piq_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/positional_insert_queue.sv @@
// ----------------------------------------------------------------------------
// positional_insert_queue
// Ordered queue of signed 32-bit values with enqueue at a chosen position,
// dequeue from the head and clear.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one operation per transaction: op, value and position.
//   rsp_ch returns exactly one result per request: status, head_value and
//   the entry count after the operation, in request order.
//   csr_ch writes max_position; it is ready in every cycle outside reset and
//   should only be used while no request is outstanding.
// Timing:
//   A request is latched at the edge it is accepted and executed once the
//   response register is free, and its result is registered in the output
//   register. The controller takes no new request until the last one has
//   executed; its two states, latch then execute, set that order.
// Stalls:
//   The result waits in an output register while rsp_ch.ready is low. One
//   new request may still be accepted; its execute step waits until the
//   pending result has been taken, and req_ch.ready stays low meanwhile.
// Reset:
//   Synchronous reset empties the queue, sets max_position to 16 and drops
//   any pending result. Entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_queue
   import piq_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   piq_req_if.sink   req_ch,
   piq_rsp_if.source rsp_ch,
   piq_csr_if.sink   csr_ch
);

   piq_cmd_type  cmd;
   piq_stat_type stat;

   // Configuration writes are taken in any cycle outside reset.
   assign csr_ch.ready = !reset;

   // Sequencing of request transactions.
   piq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Entry storage and result generation.
   piq_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_ch.op),
      .req_value      (req_ch.value),
      .req_position   (req_ch.position),
      .csr_write      (csr_ch.valid),
      .csr_data       (csr_ch.data),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_status     (rsp_ch.status),
      .rsp_head_value (rsp_ch.head_value),
      .rsp_count      (rsp_ch.count)
   );

endmodule

`default_nettype wire

@@ rtl/core/piq_ctrl.sv @@
// ----------------------------------------------------------------------------
// piq_ctrl
// Controller: takes one request transaction, then issues the execute step
// once the response register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module piq_ctrl
   import piq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   input  wire piq_stat_type stat,
   output      piq_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands. No request is taken while reset is held.
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.load    = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stat.out_busy) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/piq_datapath.sv @@
// ----------------------------------------------------------------------------
// piq_datapath
// Entry cells, count, max_position register, request latch and response
// register. All cells shift in parallel for insert and dequeue.
// ----------------------------------------------------------------------------
`default_nettype none

module piq_datapath
   import piq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire piq_cmd_type             cmd,
   output      piq_stat_type            stat,
   input  wire logic [OP_W-1:0]         req_op,
   input  wire logic [VAL_W-1:0]        req_value,
   input  wire logic [POS_W-1:0]        req_position,
   input  wire logic                    csr_write,
   input  wire logic [CNT_W-1:0]        csr_data,
   input  wire logic                    rsp_ready,
   output      logic                    rsp_valid,
   output      logic [ST_W-1:0]         rsp_status,
   output      logic signed [VAL_W-1:0] rsp_head_value,
   output      logic [CNT_W-1:0]        rsp_count
);

   logic signed [VAL_W-1:0] cell_ff [DEPTH];
   logic signed [VAL_W-1:0] cell_in [DEPTH];
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic [CNT_W-1:0]        maxpos_ff;
   op_type                  op_ff;
   logic [VAL_W-1:0]        value_ff;
   logic [POS_W-1:0]        pos_ff;
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   status_type              status_in;
   logic signed [VAL_W-1:0] rsp_head_ff;
   logic signed [VAL_W-1:0] head_in;
   logic [CNT_W-1:0]        rsp_count_ff;
   logic [CNT_W-1:0]        ins_at;
   logic                    is_full;
   logic                    is_empty;
   logic                    append;

   assign is_full  = (count_ff >= CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign append   = (pos_ff > POS_W'(maxpos_ff)) || (pos_ff > POS_W'(count_ff));
   assign ins_at   = append ? count_ff : CNT_W'(pos_ff);

   // Operation decode: new count, status and dequeued value.
   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      head_in   = '0;
      unique case (op_ff)
         OP_ENQ: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         OP_DEQ: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               head_in  = cell_ff[0];
               count_in = count_ff - 1'b1;
            end
         end
         OP_CLR: begin
            count_in = '0;
         end
         OP_NOP: begin
            count_in = count_ff;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Per-cell next value: each cell looks only at its neighbors.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
         if (op_ff == OP_ENQ && !is_full) begin
            if (i > 0 && CNT_W'(i) > ins_at) begin
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            end else if (CNT_W'(i) == ins_at) begin
               cell_in[i] = value_ff;
            end
         end else if (op_ff == OP_DEQ && !is_empty && i < DEPTH - 1) begin
            cell_in[i] = cell_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   // Entry cells.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         cell_ff <= cell_in;
      end
   end

   // Count and configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         maxpos_ff <= MAXPOS_RESET;
      end else begin
         if (cmd.execute) begin
            count_ff <= count_in;
         end
         if (csr_write) begin
            maxpos_ff <= csr_data;
         end
      end
   end

   // Request latch.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_op);
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
   end

   // Response register: holds the result until the transaction is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_status_ff <= status_in;
         rsp_head_ff   <= head_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign stat.out_busy  = rsp_valid_ff && !rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_head_value = rsp_head_ff;
   assign rsp_count      = rsp_count_ff;

   // The count never exceeds the number of cells.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // An execute step never overwrites a response that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response overwritten before it was taken");

   // A dequeue on an empty queue reports empty with a zero value and count.
   a_deq_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && op_ff == OP_DEQ && is_empty) |=>
         (rsp_valid_ff && rsp_status_ff == ST_EMPTY && rsp_head_ff == '0
          && count_ff == '0))
      else $error("empty dequeue reported wrongly");

   // A full enqueue leaves the count unchanged.
   a_enq_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && op_ff == OP_ENQ && is_full) |=>
         (rsp_status_ff == ST_FULL && count_ff == $past(count_ff)))
      else $error("full enqueue changed the queue");

endmodule

`default_nettype wire

@@ tb/tb_positional_insert_queue.sv @@
// ----------------------------------------------------------------------------
// tb_positional_insert_queue
// Self-checking testbench for the positional insert queue. A short table of
// directed operations covers empty, full, head, tail and middle inserts, then
// random bursts of fill, drain and mixed traffic run under several max_position
// settings. Every response is compared field by field against its row's fixed
// answer or an in-bench queue predictor, with random idling and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_positional_insert_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import piq_pkg::*;

   // One response as the block reports it.
   typedef struct packed {
      status_type       status;
      logic [VAL_W-1:0] head_value;
      logic [CNT_W-1:0] count;
   } queue_result_type;

   // One row of the directed table; rows with fixed_exp set carry their own answer.
   typedef struct packed {
      op_type           op;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] pos;
      logic [6:0]       reps;
      logic             fixed_exp;
      queue_result_type res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   piq_req_if req_ch ();
   piq_rsp_if rsp_ch ();
   piq_csr_if csr_ch ();

   positional_insert_queue dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predicted queue contents and register copy.
   logic [VAL_W-1:0] q_store [DEPTH];
   int               q_count;
   logic [CNT_W-1:0] max_pos;

   // Responses still owed by the block, oldest first.
   queue_result_type owed_results [$];

   // Idle percentages for both sides and the long receiver hold-off request.
   int               snd_idle_pct = 21;
   int               rcv_idle_pct = 74;
   int               hold_len     = 0;
   int               hold_seq     = 0;

   // Run statistics.
   int               errors    = 0;
   int               n_items   = 0;
   int               n_results = 0;
   int               n_full    = 0;
   int               n_empty   = 0;
   int               n_cfg     = 0;

   stim_row_type     directed_rows [24];

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Safety net in case the block hangs.
   initial begin
      #4_000_000;
      $display("tb_positional_insert_queue: FAIL");
      $finish;
   end

   // Apply one operation to the predicted queue and return its response.
   function automatic queue_result_type apply_queue_op(op_type op, logic [VAL_W-1:0] value,
                                                       logic [POS_W-1:0] pos);
      queue_result_type r;
      int               at;
      int               i;
      r.status     = ST_OK;
      r.head_value = '0;
      case (op)
         OP_ENQ: begin
            if (q_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               at = int'(pos);
               if (at > int'(max_pos) || at > q_count) at = q_count;
               for (i = q_count; i > at; i--) q_store[i] = q_store[i-1];
               q_store[at] = value;
               q_count++;
            end
         end
         OP_DEQ: begin
            if (q_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.head_value = q_store[0];
               for (i = 0; i + 1 < q_count; i++) q_store[i] = q_store[i+1];
               q_count--;
            end
         end
         OP_CLR: q_count = 0;
         default: ;
      endcase
      r.count = CNT_W'(q_count);
      return r;
   endfunction

   // Offer one request, wait for its transaction and record what it owes.
   // Entered and left at a falling edge.
   task automatic send_req(op_type op, logic [VAL_W-1:0] value, logic [POS_W-1:0] pos,
                           bit use_fixed, queue_result_type fixed_res);
      queue_result_type predicted;
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.op       <= op;
      req_ch.value    <= value;
      req_ch.position <= pos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = apply_queue_op(op, value, pos);
      owed_results.push_back(use_fixed ? fixed_res : predicted);
      n_items++;
      @(negedge clock);
   endtask

   // Stop offering and wait until every owed response has come back.
   task automatic drain_results();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      do begin
         @(negedge clock);
         guard++;
      end while (owed_results.size() != 0 && guard < 20000);
      if (owed_results.size() != 0) begin
         $error("%0d responses never arrived", owed_results.size());
         errors++;
      end
   endtask

   // Write max_position while the block is idle.
   task automatic write_max_position(logic [CNT_W-1:0] v);
      drain_results();
      repeat (4) @(negedge clock);
      csr_ch.data  <= v;
      csr_ch.valid <= 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      max_pos = v;
      n_cfg++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Random bursts: fill-heavy, drain-heavy, mixed and unfiltered noise.
   task automatic run_random_phase(int n_target);
      int               done;
      int               kind;
      int               burst_len;
      int               roll;
      int               k;
      int               p;
      op_type           op;
      logic [VAL_W-1:0] value;
      done = 0;
      while (done < n_target) begin
         kind      = $urandom_range(0, 9);
         burst_len = $urandom_range(4, 40);
         for (k = 0; k < burst_len && done < n_target; k++) begin
            roll = $urandom_range(0, 99);
            if (kind <= 3) begin
               op = (roll < 85) ? OP_ENQ : ((roll < 98) ? OP_DEQ : OP_CLR);
            end else if (kind <= 6) begin
               op = (roll < 75) ? OP_DEQ : ((roll < 99) ? OP_ENQ : OP_CLR);
            end else if (kind <= 8) begin
               op = (roll < 50) ? OP_ENQ : ((roll < 97) ? OP_DEQ : OP_NOP);
            end else begin
               op = op_type'($urandom_range(0, 3));
            end

            // Mostly random values, with the signed extremes now and then.
            if ($urandom_range(0, 9) == 0) begin
               case ($urandom_range(0, 3))
                  0:       value = 32'h0000_0000;
                  1:       value = 32'h7FFF_FFFF;
                  2:       value = 32'h8000_0000;
                  default: value = 32'hFFFF_FFFF;
               endcase
            end else begin
               value = $urandom();
            end

            // Positions near the current count, near the limit, or anywhere.
            case ($urandom_range(0, 2))
               0:       p = $urandom_range(0, q_count + 1);
               1:       p = int'(max_pos) + int'($urandom_range(0, 2)) - 1;
               default: p = $urandom_range(0, 255);
            endcase
            if (p < 0) p = 0;
            if (p > 255) p = 255;

            send_req(op, value, POS_W'(p), 1'b0, '0);
            done++;
         end
      end
   endtask

   // Receiver: random stalls, plus a long hold-off counted here on request.
   always @(negedge clock) begin : drive_rsp_ready
      int hold_left;
      int hold_ack;
      if (reset) begin
         hold_left = 0;
         hold_ack  = hold_seq;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (hold_seq != hold_ack) begin
            hold_ack  = hold_seq;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   // Compare each response transaction with the oldest owed response.
   always @(posedge clock) begin : check_results
      queue_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_results++;
         if (rsp_ch.status == ST_FULL) n_full++;
         if (rsp_ch.status == ST_EMPTY) n_empty++;
         if (owed_results.size() == 0) begin
            $error("response with none outstanding: status %0d head_value %0d count %0d",
                   rsp_ch.status, rsp_ch.head_value, rsp_ch.count);
            errors++;
         end else begin
            want = owed_results.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               errors++;
            end
            if (rsp_ch.head_value !== want.head_value) begin
               $error("head_value: expected %0d, got %0d",
                      $signed(want.head_value), rsp_ch.head_value);
               errors++;
            end
            if (rsp_ch.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
               errors++;
            end
         end
      end
   end

   // Main sequence.
   initial begin : stimulus
      int               r;
      int               k;
      int               ph;
      logic [CNT_W-1:0] phase_cfg [6];

      req_ch.valid    = 1'b0;
      req_ch.op       = OP_NOP;
      req_ch.value    = '0;
      req_ch.position = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.data     = '0;
      q_count         = 0;
      max_pos         = MAXPOS_RESET;

      // Directed rows, run with max_position at its reset value of 16.
      directed_rows = '{
         '{OP_DEQ, 32'h0000_0000, 8'd0,   7'd1,  1'b1, '{ST_EMPTY, 32'h0, 6'd0}},
         '{OP_NOP, 32'hFFFF_FFFF, 8'd0,   7'd1,  1'b1, '{ST_OK, 32'h0, 6'd0}},
         '{OP_CLR, 32'h1234_5678, 8'd9,   7'd1,  1'b1, '{ST_OK, 32'h0, 6'd0}},
         '{OP_ENQ, 32'h7FFF_FFFF, 8'd255, 7'd1,  1'b1, '{ST_OK, 32'h0, 6'd1}},
         '{OP_ENQ, 32'h8000_0000, 8'd0,   7'd1,  1'b1, '{ST_OK, 32'h0, 6'd2}},
         '{OP_ENQ, 32'hFFFF_FFFF, 8'd2,   7'd1,  1'b1, '{ST_OK, 32'h0, 6'd3}},
         '{OP_ENQ, 32'h0000_0005, 8'd1,   7'd1,  1'b1, '{ST_OK, 32'h0, 6'd4}},
         '{OP_ENQ, 32'h0000_0006, 8'd16,  7'd1,  1'b1, '{ST_OK, 32'h0, 6'd5}},
         '{OP_ENQ, 32'h0000_0007, 8'd17,  7'd1,  1'b1, '{ST_OK, 32'h0, 6'd6}},
         '{OP_DEQ, 32'h0000_0000, 8'd0,   7'd1,  1'b1, '{ST_OK, 32'h8000_0000, 6'd5}},
         '{OP_DEQ, 32'h0000_0000, 8'd0,   7'd1,  1'b0, '0},
         '{OP_DEQ, 32'h0000_0000, 8'd0,   7'd1,  1'b0, '0},
         '{OP_NOP, 32'h0000_0000, 8'd0,   7'd1,  1'b1, '{ST_OK, 32'h0, 6'd3}},
         '{OP_CLR, 32'h0000_0000, 8'd0,   7'd1,  1'b1, '{ST_OK, 32'h0, 6'd0}},
         '{OP_ENQ, 32'h0000_0100, 8'd1,   7'd32, 1'b0, '0},
         '{OP_ENQ, 32'h0000_0055, 8'd0,   7'd1,  1'b1, '{ST_FULL, 32'h0, 6'd32}},
         '{OP_NOP, 32'h0000_0000, 8'd0,   7'd1,  1'b1, '{ST_OK, 32'h0, 6'd32}},
         '{OP_DEQ, 32'h0000_0000, 8'd0,   7'd1,  1'b0, '0},
         '{OP_ENQ, 32'hAAAA_5555, 8'd0,   7'd1,  1'b0, '0},
         '{OP_ENQ, 32'h0000_0001, 8'd3,   7'd1,  1'b1, '{ST_FULL, 32'h0, 6'd32}},
         '{OP_CLR, 32'h0000_0000, 8'd0,   7'd1,  1'b1, '{ST_OK, 32'h0, 6'd0}},
         '{OP_ENQ, 32'h0000_0000, 8'd128, 7'd1,  1'b1, '{ST_OK, 32'h0, 6'd1}},
         '{OP_DEQ, 32'h0000_0000, 8'd0,   7'd1,  1'b1, '{ST_OK, 32'h0, 6'd0}},
         '{OP_DEQ, 32'h0000_0000, 8'd0,   7'd1,  1'b1, '{ST_EMPTY, 32'h0, 6'd0}}
      };

      // Hold reset, then release it at a falling edge.
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table; a row with several repeats steps its value.
      for (r = 0; r < 24; r++) begin
         for (k = 0; k < int'(directed_rows[r].reps); k++) begin
            send_req(directed_rows[r].op, directed_rows[r].value + VAL_W'(k),
                     directed_rows[r].pos, directed_rows[r].fixed_exp, directed_rows[r].res);
         end
      end

      // Random phases, each under its own max_position, extremes included.
      phase_cfg = '{6'd0, 6'd32, 6'd63, 6'd1, 6'd0, 6'd31};
      phase_cfg[4] = CNT_W'($urandom_range(0, 32));
      for (ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin
            snd_idle_pct = 74;
            rcv_idle_pct = 21;
         end else if (ph == 4) begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         write_max_position(phase_cfg[ph]);

         // Long receiver hold-off while requests keep coming, to back up the block.
         if (ph == 0 || ph == 4) begin
            hold_len <= 150;
            hold_seq <= hold_seq + 1;
         end
         run_random_phase(125);

         // A sender pause until every response has come back.
         if (ph == 2) drain_results();
         run_random_phase(125);
      end

      drain_results();
      repeat (8) @(negedge clock);

      $display("Ran %0d requests and checked %0d responses (%0d full drops, %0d empty dequeues).",
               n_items, n_results, n_full, n_empty);
      $display("Used %0d max_position settings including 0, 32 and 63, with both sides stalling.",
               n_cfg + 1);
      if (errors == 0) begin
         $display("tb_positional_insert_queue: PASS");
      end else begin
         $display("tb_positional_insert_queue: FAIL");
      end
      $finish;
   end

endmodule
